>>> design/rsc_pkg.sv
`default_nettype none
package rsc_pkg;

	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned LIMIT_W   = 26;
	localparam logic [9:0]  MS_PER_S  = 10'd1000;

	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_TRIGGER = 2'd1;
	localparam logic [1:0] KIND_COMMAND = 2'd2;
	localparam logic [1:0] KIND_FRAME   = 2'd3;

	localparam logic [2:0] CMD_MAN_START = 3'd0;
	localparam logic [2:0] CMD_MAN_STOP  = 3'd1;
	localparam logic [2:0] CMD_LEARN     = 3'd2;
	localparam logic [2:0] CMD_RESTART   = 3'd3;
	localparam logic [2:0] CMD_UPD_START = 3'd4;
	localparam logic [2:0] CMD_UPD_END   = 3'd5;

	localparam logic [1:0] MODE_READY   = 2'd0;
	localparam logic [1:0] MODE_MONITOR = 2'd1;
	localparam logic [1:0] MODE_RECORD  = 2'd2;
	localparam logic [1:0] MODE_MAINT   = 2'd3;

	localparam logic [1:0] VERDICT_PASS      = 2'd0;
	localparam logic [1:0] VERDICT_TEST_FAIL = 2'd1;
	localparam logic [1:0] VERDICT_RULE_FAIL = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MIN_ENERGY    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ENERGY_LIMIT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STDDEV_LIMIT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RATIO_LIMIT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TRIAL_SECONDS = 3'd4;

	typedef enum logic [3:0] {
		ST_READY   = 4'b0001,
		ST_MONITOR = 4'b0010,
		ST_RECORD  = 4'b0100,
		ST_MAINT   = 4'b1000
	} state_t;

	typedef struct packed {
		logic pause;
		logic close;
		logic resume;
		logic freset;
	} mode_fx_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] trial_number;
		logic [1:0] verdict;
		logic       open_session;
		logic       close_session;
		logic       mic_pause;
		logic       mic_resume;
		logic       filter_reset;
		logic       noise_learn_write;
		logic       noise_learn_value;
		logic       publish;
		logic       reboot_request;
	} result_t;

	function automatic logic [1:0] state_to_mode(input state_t s);
		logic [1:0] m;
		unique case (s)
			ST_READY:   m = MODE_READY;
			ST_MONITOR: m = MODE_MONITOR;
			ST_RECORD:  m = MODE_RECORD;
			ST_MAINT:   m = MODE_MAINT;
			default:    m = MODE_READY;
		endcase
		return m;
	endfunction

	function automatic state_t mode_to_state(input logic [1:0] m);
		state_t s;
		unique case (m)
			MODE_READY:   s = ST_READY;
			MODE_MONITOR: s = ST_MONITOR;
			MODE_RECORD:  s = ST_RECORD;
			MODE_MAINT:   s = ST_MAINT;
			default:      s = ST_READY;
		endcase
		return s;
	endfunction

	// side effects of a mode change
	function automatic mode_fx_t mode_fx(input logic [1:0] prev, input logic [1:0] next);
		mode_fx_t fx;
		fx = '0;
		if (prev != next) begin
			if (next == MODE_READY) begin
				fx.pause = 1'b1;
			end else if (next == MODE_MAINT) begin
				fx.pause = 1'b1;
				fx.close = 1'b1;
			end else if (prev == MODE_READY) begin
				fx.resume = 1'b1;
				fx.freset = 1'b1;
			end
		end
		return fx;
	endfunction

endpackage
`default_nettype wire

>>> design/recording_session_controller_top.sv
// Recording session controller.
// Item channel: one event per beat (kind = tick, trigger change, command or
// processed frame) with item_valid / item_stall. Result channel: one result
// beat per item (mode, trial number, verdict and action strobes) with
// result_valid / result_stall. Strobes are meaningful only on an accepted
// result beat.
// Configuration: cfg_valid / cfg_ready write port, cfg_index selects the
// threshold or trial length register; indexes beyond the list are dropped.
// cfg_ready is always high. Write configuration only while the block is idle.
// Path: an item passes the input register, then the result register.
// Throughput: one item per cycle while the receiver does not stall; the
// state update is a single pass of compare and update logic.
// Reset (arst_n low): ready mode, trigger low, trial count and elapsed time
// zero, thresholds to their defaults, both pipeline stages empty.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more item if it is empty, then item_stall rises.
`default_nettype none
module recording_session_controller_top
	import rsc_pkg::*;
#(
	parameter int unsigned MAX_TRIALS = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,

	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [1:0]           kind,
	input  wire logic                 trigger_level,
	input  wire logic [2:0]           command,
	input  wire logic [31:0]          energy,
	input  wire logic [31:0]          pooled_stddev,
	input  wire logic [31:0]          sta_lta,

	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [1:0]                mode,
	output logic [7:0]                trial_number,
	output logic [1:0]                verdict,
	output logic                      open_session,
	output logic                      close_session,
	output logic                      mic_pause,
	output logic                      mic_resume,
	output logic                      filter_reset,
	output logic                      noise_learn_write,
	output logic                      noise_learn_value,
	output logic                      publish,
	output logic                      reboot_request
);

	localparam logic [7:0] MAX_TRIALS_C = 8'(MAX_TRIALS);

	// configuration
	logic [31:0] min_energy_q, energy_limit_q, stddev_limit_q, ratio_limit_q;
	logic [15:0] trial_seconds_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic        trig_s1;
	logic [2:0]  cmd_s1;
	logic [31:0] energy_s1, stddev_s1, ratio_s1;

	// controller state
	state_t      state_q;
	logic        trigger_q;
	logic        manual_q;
	logic [7:0]  trial_q;
	logic [31:0] elapsed_q;

	// result stage
	logic        result_valid_q;
	result_t     result_q;

	logic        adv_s1;
	logic        upd;

	logic [1:0]         m_n;
	logic               trig_n;
	logic               man_n;
	logic [7:0]         cnt_n;
	logic [31:0]        el_n;
	result_t            r;
	mode_fx_t           fx;
	logic               sup;
	logic [1:0]         v;
	logic [1:0]         tgt;
	logic [LIMIT_W-1:0] limit;

	assign cfg_ready  = 1'b1;
	assign adv_s1     = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !adv_s1;
	assign upd        = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_energy_q    <= '0;
			energy_limit_q  <= '1;
			stddev_limit_q  <= '1;
			ratio_limit_q   <= '1;
			trial_seconds_q <= 16'd5;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_ENERGY:    min_energy_q    <= cfg_data;
				REG_ENERGY_LIMIT:  energy_limit_q  <= cfg_data;
				REG_STDDEV_LIMIT:  stddev_limit_q  <= cfg_data;
				REG_RATIO_LIMIT:   ratio_limit_q   <= cfg_data;
				REG_TRIAL_SECONDS: trial_seconds_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			kind_s1   <= kind;
			trig_s1   <= trigger_level;
			cmd_s1    <= command;
			energy_s1 <= energy;
			stddev_s1 <= pooled_stddev;
			ratio_s1  <= sta_lta;
		end
	end

	assign limit = LIMIT_W'(trial_seconds_q) * LIMIT_W'(MS_PER_S);

	always_comb begin
		m_n    = state_to_mode(state_q);
		trig_n = trigger_q;
		man_n  = manual_q;
		cnt_n  = trial_q;
		el_n   = elapsed_q;
		r      = '0;
		fx     = '0;
		sup    = 1'b0;
		v      = VERDICT_PASS;
		tgt    = trigger_q ? MODE_MONITOR : MODE_READY;

		unique case (kind_s1)
			KIND_TICK: begin
				if (el_n != '1) begin
					el_n = el_n + 32'd1;
				end
				sup = 1'b1;
			end
			KIND_TRIGGER: begin
				trig_n = trig_s1;
				sup    = 1'b1;
			end
			KIND_COMMAND: begin
				if (m_n != MODE_MAINT || cmd_s1 == CMD_RESTART || cmd_s1 == CMD_UPD_END) begin
					unique case (cmd_s1)
						CMD_MAN_START: begin
							if (m_n == MODE_MONITOR || m_n == MODE_READY) begin
								man_n          = 1'b1;
								fx             = mode_fx(m_n, MODE_RECORD);
								m_n            = MODE_RECORD;
								r.open_session = 1'b1;
								el_n           = '0;
							end
						end
						CMD_MAN_STOP: begin
							if (m_n == MODE_RECORD && man_n) begin
								man_n           = 1'b0;
								r.close_session = 1'b1;
								fx              = mode_fx(m_n, tgt);
								m_n             = tgt;
							end
						end
						CMD_LEARN: begin
							r.noise_learn_write = 1'b1;
							r.noise_learn_value = 1'b1;
						end
						CMD_RESTART: begin
							r.close_session  = 1'b1;
							r.reboot_request = 1'b1;
						end
						CMD_UPD_START: begin
							fx  = mode_fx(m_n, MODE_MAINT);
							m_n = MODE_MAINT;
						end
						CMD_UPD_END: begin
							if (m_n == MODE_MAINT) begin
								fx  = mode_fx(m_n, MODE_READY);
								m_n = MODE_READY;
							end
						end
						default: ;
					endcase
				end
			end
			KIND_FRAME: begin
				priority if (energy_s1 < min_energy_q) begin
					v = VERDICT_TEST_FAIL;
				end else if (energy_s1 > energy_limit_q || stddev_s1 > stddev_limit_q ||
						ratio_s1 > ratio_limit_q) begin
					v = VERDICT_RULE_FAIL;
				end else begin
					v = VERDICT_PASS;
				end
				r.verdict = v;
				if (v != VERDICT_PASS) begin
					if (m_n == MODE_MONITOR) begin
						fx             = mode_fx(m_n, MODE_RECORD);
						m_n            = MODE_RECORD;
						r.open_session = 1'b1;
						el_n           = '0;
					end
					r.publish = 1'b1;
				end
				if (m_n == MODE_RECORD && !man_n && el_n > 32'(limit)) begin
					if (cnt_n < MAX_TRIALS_C) begin
						r.noise_learn_write = 1'b1;
						r.noise_learn_value = (cnt_n == 8'd0);
						cnt_n               = cnt_n + 8'd1;
						el_n                = '0;
					end else begin
						r.close_session = 1'b1;
						fx              = mode_fx(m_n, tgt);
						m_n             = tgt;
						cnt_n           = '0;
					end
				end
			end
			default: ;
		endcase

		// trigger supervision after ticks and trigger changes
		if (sup && m_n != MODE_MAINT) begin
			if (!trig_n && m_n != MODE_READY && !man_n) begin
				if (m_n == MODE_RECORD) begin
					r.close_session = 1'b1;
				end
				fx  = mode_fx(m_n, MODE_READY);
				m_n = MODE_READY;
			end else if (trig_n && m_n == MODE_READY) begin
				fx                  = mode_fx(m_n, MODE_RECORD);
				m_n                 = MODE_RECORD;
				cnt_n               = 8'd1;
				el_n                = '0;
				r.open_session      = 1'b1;
				r.noise_learn_write = 1'b1;
				r.noise_learn_value = 1'b1;
			end
		end

		r.mic_pause     = fx.pause;
		r.close_session = r.close_session | fx.close;
		r.mic_resume    = fx.resume;
		r.filter_reset  = fx.freset;
		r.mode          = m_n;
		r.trial_number  = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_READY;
			trigger_q      <= 1'b0;
			manual_q       <= 1'b0;
			trial_q        <= '0;
			elapsed_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				result_valid_q <= valid_s1;
			end
			if (upd) begin
				state_q   <= mode_to_state(m_n);
				trigger_q <= trig_n;
				manual_q  <= man_n;
				trial_q   <= cnt_n;
				elapsed_q <= el_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			result_q <= r;
		end
	end

	assign result_valid      = result_valid_q;
	assign mode              = result_q.mode;
	assign trial_number      = result_q.trial_number;
	assign verdict           = result_q.verdict;
	assign open_session      = result_q.open_session;
	assign close_session     = result_q.close_session;
	assign mic_pause         = result_q.mic_pause;
	assign mic_resume        = result_q.mic_resume;
	assign filter_reset      = result_q.filter_reset;
	assign noise_learn_write = result_q.noise_learn_write;
	assign noise_learn_value = result_q.noise_learn_value;
	assign publish           = result_q.publish;
	assign reboot_request    = result_q.reboot_request;

	a_state_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(upd) |-> $stable(state_q))
		else $error("state changed without an item");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> result_valid)
		else $error("item lost between stages");

	a_open_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && open_session |-> mode == MODE_RECORD)
		else $error("session opened outside recording");

	a_reboot_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && reboot_request |-> close_session && mode == state_to_mode(state_q))
		else $error("reboot without close");

	a_resume_resets: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mic_resume |-> filter_reset && !mic_pause)
		else $error("resume without filter reset");

endmodule
`default_nettype wire
